[rtl/ssc_pkg.sv]
// Shared types and constants for the serial servo command parser.
`default_nettype none

package ssc_pkg;

   localparam int unsigned CMP_W   = 10;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ACC_W   = 20;  // angle * 13, signed
   localparam int unsigned MAG_W   = 19;
   localparam int unsigned QUOT_W  = 16;

   localparam logic [CMP_W-1:0] PWM_MIN_RESET = 10'd245;
   localparam logic [CMP_W-1:0] PWM_MAX_RESET = 10'd505;
   localparam logic [CMP_W-1:0] CMP_RESET     = 10'd245;

   localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] ASCII_THREE = 8'h33;

   // 260/180 == 13/9; digit weights are pre-scaled by 13
   localparam logic signed [11:0] WEIGHT_HUNDREDS = 12'sd1300;
   localparam logic signed [11:0] WEIGHT_TENS     = 12'sd130;
   localparam logic signed [11:0] WEIGHT_ONES     = 12'sd13;

   // floor(m / 9) == (m * ceil(2^23 / 9)) >> 23 for m < 2^21
   localparam int unsigned       DIV9_SHIFT = 23;
   localparam logic [ACC_W-1:0]  DIV9_RECIP = 20'd932068;

   localparam logic [1:0] SERVO_A    = 2'd0;
   localparam logic [1:0] SERVO_B    = 2'd1;
   localparam logic [1:0] DIGITS_FULL = 2'd3;

   localparam logic REG_PWM_MIN = 1'b0;
   localparam logic REG_PWM_MAX = 1'b1;

   typedef enum logic [2:0] {
      PH_SELECT = 3'b001,
      PH_LED    = 3'b010,
      PH_POS    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      logic [CMP_W-1:0]  compare_a;
      logic [CMP_W-1:0]  compare_b;
      logic              led_a;
      logic              led_b;
      logic              updated;
   } result_type;

endpackage

`default_nettype wire

[rtl/ssc_csr.sv]
// APB-style register file holding the pulse width clamp limits.
`default_nettype none

module ssc_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output      logic [31:0]               csr_prdata,
   output      logic                      csr_pready,
   output      logic [ssc_pkg::CMP_W-1:0] pwm_min,
   output      logic [ssc_pkg::CMP_W-1:0] pwm_max
);
   import ssc_pkg::*;

   logic [CMP_W-1:0] pwm_min_ff, pwm_min_in;
   logic [CMP_W-1:0] pwm_max_ff, pwm_max_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      pwm_min_in = pwm_min_ff;
      pwm_max_in = pwm_max_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_PWM_MIN) pwm_min_in = csr_pwdata[CMP_W-1:0];
         else                             pwm_max_in = csr_pwdata[CMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_min_ff <= PWM_MIN_RESET;
         pwm_max_ff <= PWM_MAX_RESET;
      end else begin
         pwm_min_ff <= pwm_min_in;
         pwm_max_ff <= pwm_max_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PWM_MAX) csr_prdata[CMP_W-1:0] = pwm_max_ff;
      else                             csr_prdata[CMP_W-1:0] = pwm_min_ff;
   end

   assign pwm_min = pwm_min_ff;
   assign pwm_max = pwm_max_ff;

endmodule

`default_nettype wire

[rtl/ssc_pwm.sv]
// Angle to compare value: divide by 9, add offset, clamp.
`default_nettype none

module ssc_pwm (
   input  wire logic signed [ssc_pkg::ACC_W-1:0] acc,
   input  wire logic        [ssc_pkg::CMP_W-1:0] pwm_min,
   input  wire logic        [ssc_pkg::CMP_W-1:0] pwm_max,
   output      logic        [ssc_pkg::CMP_W-1:0] pwm
);
   import ssc_pkg::*;

   logic                       neg;
   logic signed [ACC_W-1:0]    acc_abs;
   logic [MAG_W-1:0]           mag;
   logic [MAG_W+ACC_W-1:0]     prod;
   logic [QUOT_W-1:0]          quot;
   logic signed [QUOT_W:0]     offset;
   logic signed [QUOT_W+1:0]   sum;

   assign neg     = acc[ACC_W-1];
   assign acc_abs = neg ? -acc : acc;
   assign mag     = acc_abs[MAG_W-1:0];
   assign prod    = (MAG_W+ACC_W)'(mag) * (MAG_W+ACC_W)'(DIV9_RECIP);
   assign quot    = prod[DIV9_SHIFT +: QUOT_W];
   // truncation toward zero: divide the magnitude, then restore the sign
   assign offset  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign sum     = $signed({{(QUOT_W+2-CMP_W){1'b0}}, pwm_min})
                    + (QUOT_W+2)'(offset);

   always_comb begin
      priority if (offset < 0) begin
         pwm = pwm_min;
      end else if (sum > $signed({{(QUOT_W+2-CMP_W){1'b0}}, pwm_max})) begin
         pwm = pwm_max;
      end else begin
         pwm = sum[CMP_W-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/ssc_parser.sv]
// Command parser: phase sequencer, digit accumulator, LED and compare state.
`default_nettype none

module ssc_parser (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic        [ssc_pkg::BYTE_W-1:0]  rx_byte,
   input  wire logic        [ssc_pkg::CMP_W-1:0]   pwm,
   output      logic signed [ssc_pkg::ACC_W-1:0]   acc,
   output      ssc_pkg::result_type                result
);
   import ssc_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [1:0]              servo_ff, servo_in;
   logic [1:0]              count_ff, count_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [CMP_W-1:0]        cmp_a_ff, cmp_a_in;
   logic [CMP_W-1:0]        cmp_b_ff, cmp_b_in;
   logic [1:0]              led_ff, led_in;
   logic                    updated;

   logic [1:0]              led_mask;
   logic signed [8:0]       digit;
   logic signed [11:0]      weight;
   logic signed [20:0]      term;

   always_comb begin
      unique case (servo_ff)
         SERVO_A: led_mask = 2'b01;
         SERVO_B: led_mask = 2'b10;
         default: led_mask = 2'b11;
      endcase
   end

   assign digit = $signed({1'b0, rx_byte}) - $signed({1'b0, ASCII_ZERO});

   always_comb begin
      unique case (count_ff)
         2'd0:    weight = WEIGHT_HUNDREDS;
         2'd1:    weight = WEIGHT_TENS;
         default: weight = WEIGHT_ONES;
      endcase
   end

   assign term = digit * weight;

   always_comb begin
      phase_in = phase_ff;
      servo_in = servo_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      cmp_a_in = cmp_a_ff;
      cmp_b_in = cmp_b_ff;
      led_in   = led_ff;
      updated  = 1'b0;
      unique case (phase_ff)
         PH_LED: begin
            if (rx_byte == ASCII_ZERO) led_in = led_ff & ~led_mask;
            else                       led_in = led_ff | led_mask;
            phase_in = PH_POS;
         end
         PH_POS: begin
            if (count_ff == DIGITS_FULL) begin
               if (servo_ff != SERVO_B) cmp_a_in = pwm;
               if (servo_ff != SERVO_A) cmp_b_in = pwm;
               acc_in   = '0;
               count_in = '0;
               phase_in = PH_SELECT;
               updated  = 1'b1;
            end else begin
               acc_in   = acc_ff + term[ACC_W-1:0];
               count_in = count_ff + 2'd1;
            end
         end
         default: begin
            // select phase; an unknown phase code behaves the same way
            if (rx_byte >= ASCII_ONE && rx_byte <= ASCII_THREE) begin
               servo_in = 2'(rx_byte - ASCII_ONE);
               phase_in = PH_LED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SELECT;
         servo_ff <= SERVO_A;
         count_ff <= '0;
         acc_ff   <= '0;
         cmp_a_ff <= CMP_RESET;
         cmp_b_ff <= CMP_RESET;
         led_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         servo_ff <= servo_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         cmp_a_ff <= cmp_a_in;
         cmp_b_ff <= cmp_b_in;
         led_ff   <= led_in;
      end
   end

   assign acc = acc_ff;

   assign result.echo_byte = rx_byte;
   assign result.compare_a = cmp_a_in;
   assign result.compare_b = cmp_b_in;
   assign result.led_a     = led_in[0];
   assign result.led_b     = led_in[1];
   assign result.updated   = updated;

endmodule

`default_nettype wire

[rtl/serial_servo_command_parser.sv]
// Serial servo command parser: top level with input and result registers.
//
// Usage: received serial bytes enter on the req_ channel (req_rx_byte), one
// beat per byte. Every byte yields exactly one rsp_ beat carrying the echoed
// byte, both servo compare values, both LED bits and an updated flag that is
// set on the terminator byte of a position command. The clamp limits pwm_min
// (address 0) and pwm_max (address 4) are written through the csr_ port.
// Flow: a beat accepted into the input register is processed out of it into
// the result register and offered on rsp_ from then on; while the result
// register is full and not taken, the beat waits in the input register.
// Throughput is one beat per cycle while rsp_ready is high; the path from
// input register to result register holds one reciprocal multiply for the
// divide by nine plus an add and a clamp.
// Reset (synchronous) empties both registers, returns the parser to servo
// select, clears LEDs and digits, and sets both compares and pwm_min to 245,
// pwm_max to 505. When rsp_ready is low the result register holds, one more
// beat waits in the input register, and req_ready then drops.
`default_nettype none

module serial_servo_command_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_echo_byte,
   output      logic [9:0]  rsp_compare_a,
   output      logic [9:0]  rsp_compare_b,
   output      logic        rsp_led_a,
   output      logic        rsp_led_b,
   output      logic        rsp_updated,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import ssc_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]       in_byte_ff;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_ff;
   result_type              result;
   logic                    advance;
   logic                    req_take;
   logic [CMP_W-1:0]        pwm_min;
   logic [CMP_W-1:0]        pwm_max;
   logic [CMP_W-1:0]        pwm;
   logic signed [ACC_W-1:0] acc;

   ssc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pwm_min     (pwm_min),
      .pwm_max     (pwm_max)
   );

   ssc_pwm u_pwm (
      .acc     (acc),
      .pwm_min (pwm_min),
      .pwm_max (pwm_max),
      .pwm     (pwm)
   );

   ssc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .pwm     (pwm),
      .acc     (acc),
      .result  (result)
   );

   assign advance      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready    = ~in_valid_ff | advance;
   assign req_take     = req_valid & req_ready;
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_rx_byte;
      if (advance)  out_ff     <= result;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_echo_byte = out_ff.echo_byte;
   assign rsp_compare_a = out_ff.compare_a;
   assign rsp_compare_b = out_ff.compare_b;
   assign rsp_led_a     = out_ff.led_a;
   assign rsp_led_b     = out_ff.led_b;
   assign rsp_updated   = out_ff.updated;

endmodule

`default_nettype wire
